// ===== hdl/baro_pressure_temp_compensation_defines.svh =====
// Assertion macros for the barometric compensation block.
// Taken in by the top level; needs nothing else.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// Next-cycle implication, disabled while in reset.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

// ===== hdl/bpc_pkg.sv =====
// Package for the barometric compensation block: constants, codes, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int DIV_W    = 32;
    localparam int PIPE_LAT = 2 * DIV_W + 9;

    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_P_A     = 32'd3038;
    localparam logic [31:0] C_P_B     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_C     = 32'd3791;
    localparam logic [31:0] C_B7_BASE = 32'd50000;
    localparam logic [31:0] C_B4_BIAS = 32'd32768;

    localparam logic signed [31:0] T_MIN = -32'sd2048;
    localparam logic signed [31:0] T_MAX = 32'sd2047;
    localparam logic signed [31:0] P_MAX = 32'sd262143;

    typedef enum logic [1:0] {
        CFG_CAL_A = 2'd0,
        CFG_CAL_B = 2'd1,
        CFG_CAL_C = 2'd2,
        CFG_OSS   = 2'd3
    } cfg_index_t;

    // sideband alongside the temperature divider
    typedef struct packed {
        logic [31:0] x1t;
        logic        neg;
        logic        err;
        logic [23:0] up;
    } side1_t;

    // sideband alongside the pressure divider
    typedef struct packed {
        logic        hi;
        logic        err;
        logic [11:0] t;
    } side2_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bpc_channels.sv =====
// Valid/ready channel interfaces for readings in and results out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;

    modport source (output valid, output raw_temperature, output raw_pressure_bytes,
                    input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure_bytes,
                  output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature_tenths;
    logic        [17:0] pressure_pa;
    logic               divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink (input valid, input temperature_tenths, input pressure_pa,
                  input divide_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_udiv.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg (DIV_W).
`timescale 1ns / 1ps
`default_nettype none
module bpc_udiv (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [bpc_pkg::DIV_W-1:0] num,
    input  wire logic [bpc_pkg::DIV_W-1:0] den,
    output logic      [bpc_pkg::DIV_W-1:0] quo
);
    import bpc_pkg::*;

    logic [DIV_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] num_reg [DIV_W];
    logic [DIV_W-1:0] den_reg [DIV_W];
    logic [DIV_W-1:0] quo_reg [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] prev_rem;
        logic [DIV_W-1:0] prev_num;
        logic [DIV_W-1:0] prev_den;
        logic [DIV_W-1:0] prev_quo;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign prev_rem = '0;
            assign prev_num = num;
            assign prev_den = den;
            assign prev_quo = '0;
        end
        else begin : g_rest
            assign prev_rem = rem_reg[k-1];
            assign prev_num = num_reg[k-1];
            assign prev_den = den_reg[k-1];
            assign prev_quo = quo_reg[k-1];
        end

        assign trial = {prev_rem, prev_num[DIV_W-1-k]};
        assign diff  = trial - {1'b0, prev_den};
        assign ge    = (trial >= {1'b0, prev_den});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                num_reg[k] <= prev_num;
                den_reg[k] <= prev_den;
                quo_reg[k] <= {prev_quo[DIV_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[DIV_W-1];

endmodule
`default_nettype wire

// ===== hdl/baro_pressure_temp_compensation.sv =====
// Barometric sensor integer compensation, top level: config registers and datapath.
// Depends on bpc_pkg, bpc_channels (bpc_in_if, bpc_out_if), bpc_udiv and the defines header.
//
// Usage:
//  - in_ch carries one raw reading (temperature word, 24-bit pressure bytes);
//    a transfer happens when valid and ready are both high at a clock edge.
//  - out_ch returns one result per reading, in order: temperature in tenths of
//    a degree (saturated to 12 bits), pressure in pascals (0..262143) and a
//    divide error flag (results then zero).
//  - cfg_we/cfg_index/cfg_data write the three packed calibration words and
//    the oversampling setting; write only while no reading is in flight.
//  - From input transfer to output valid a reading passes one input stage,
//    a 32-stage temperature divider, five multiply stages, a 32-stage
//    pressure divider and three correction/output stages.
//  - Throughput is one reading per cycle while the receiver does not stall;
//    the two bit-per-stage dividers set the depth, not the rate.
//  - A stalled receiver freezes the whole pipeline (one global enable); in_ch
//    ready drops only while a result sits unaccepted at the output.
//  - Reset clears the valid bits and loads calibration 0, oversampling 3.
`timescale 1ns / 1ps
`default_nettype none
`include "baro_pressure_temp_compensation_defines.svh"
module baro_pressure_temp_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bpc_in_if.sink           in_ch,
    bpc_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import bpc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [47:0] cal_c_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAL_A: cal_a_reg <= cfg_data;
                CFG_CAL_B: cal_b_reg <= cfg_data;
                CFG_CAL_C: cal_c_reg <= cfg_data[47:0];
                CFG_OSS:   oss_reg   <= cfg_data[1:0];
            endcase
        end
    end

    // calibration words, widened to the 32-bit datapath
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{cal_a_reg[63]}}, cal_a_reg[63:48]};
    assign ac2 = {{16{cal_a_reg[47]}}, cal_a_reg[47:32]};
    assign ac3 = {{16{cal_a_reg[31]}}, cal_a_reg[31:16]};
    assign ac4 = {16'd0, cal_a_reg[15:0]};
    assign ac5 = {16'd0, cal_b_reg[63:48]};
    assign ac6 = {16'd0, cal_b_reg[47:32]};
    assign b1  = {{16{cal_b_reg[31]}}, cal_b_reg[31:16]};
    assign b2  = {{16{cal_b_reg[15]}}, cal_b_reg[15:0]};
    assign mc  = {{16{cal_c_reg[31]}}, cal_c_reg[31:16]};
    assign md  = {{16{cal_c_reg[15]}}, cal_c_reg[15:0]};

    // ---------------- flow control ----------------
    logic [PIPE_LAT-1:0] valid_pipe_reg;
    logic                en;

    assign en          = !valid_pipe_reg[PIPE_LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else if (en)
            valid_pipe_reg <= {valid_pipe_reg[PIPE_LAT-2:0], in_ch.valid};
    end

    // ---------------- S1: temperature X1 and divider operands ----------------
    logic [31:0] ut32, mul_t, x1t, d_t, num_t;
    logic [31:0] up32;
    side1_t      s1_side_next;
    logic [31:0] s1_num_reg, s1_den_reg;
    side1_t      s1_side_reg;

    always_comb
    begin
        ut32  = {16'd0, in_ch.raw_temperature};
        mul_t = (ut32 - ac6) * ac5;
        x1t   = asr32(mul_t, 5'd15);
        d_t   = x1t + md;
        num_t = mc << 11;
        up32  = {8'd0, in_ch.raw_pressure_bytes} >> (4'd8 - {2'd0, oss_reg});
        s1_side_next.x1t = x1t;
        s1_side_next.neg = num_t[31] ^ d_t[31];
        s1_side_next.err = (d_t == '0);
        s1_side_next.up  = up32[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_num_reg  <= num_t[31] ? (32'd0 - num_t) : num_t;
            s1_den_reg  <= d_t[31] ? (32'd0 - d_t) : d_t;
            s1_side_reg <= s1_side_next;
        end
    end

    // ---------------- temperature divider ----------------
    logic [31:0] quo1;
    side1_t      side1_pipe_reg [DIV_W];

    bpc_udiv u_div_t (
        .clk (clk),
        .en  (en),
        .num (s1_num_reg),
        .den (s1_den_reg),
        .quo (quo1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_pipe_reg[0] <= s1_side_reg;
            for (int k = 1; k < DIV_W; k++)
                side1_pipe_reg[k] <= side1_pipe_reg[k-1];
        end
    end

    // ---------------- S2: B5, temperature, B6 ----------------
    side1_t      sd1;
    logic [31:0] x2t, b5, t32;
    logic [11:0] t_sat;
    logic [31:0] s2_b6_reg;
    logic [11:0] s2_t_reg;
    logic        s2_err_reg;
    logic [23:0] s2_up_reg;

    always_comb
    begin
        sd1 = side1_pipe_reg[DIV_W-1];
        x2t = sd1.neg ? (32'd0 - quo1) : quo1;
        b5  = sd1.x1t + x2t;
        t32 = asr32(b5 + 32'd8, 5'd4);
        if ($signed(t32) < T_MIN)
            t_sat = T_MIN[11:0];
        else if ($signed(t32) > T_MAX)
            t_sat = T_MAX[11:0];
        else
            t_sat = t32[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_b6_reg  <= b5 - C_B6_OFS;
            s2_t_reg   <= t_sat;
            s2_err_reg <= sd1.err;
            s2_up_reg  <= sd1.up;
        end
    end

    // ---------------- S3: first products of B6 ----------------
    logic [31:0] s3_sq_reg, s3_m2_reg, s3_m3_reg;
    logic [11:0] s3_t_reg;
    logic        s3_err_reg;
    logic [23:0] s3_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sq_reg  <= s2_b6_reg * s2_b6_reg;
            s3_m2_reg  <= ac2 * s2_b6_reg;
            s3_m3_reg  <= ac3 * s2_b6_reg;
            s3_t_reg   <= s2_t_reg;
            s3_err_reg <= s2_err_reg;
            s3_up_reg  <= s2_up_reg;
        end
    end

    // ---------------- S4: B2 and B1 terms ----------------
    logic [31:0] sq12;
    logic [31:0] s4_x1_reg, s4_x2_reg, s4_a2_reg, s4_a3_reg;
    logic [11:0] s4_t_reg;
    logic        s4_err_reg;
    logic [23:0] s4_up_reg;

    assign sq12 = asr32(s3_sq_reg, 5'd12);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_x1_reg  <= sq12 * b2;
            s4_x2_reg  <= sq12 * b1;
            s4_a2_reg  <= asr32(s3_m2_reg, 5'd11);
            s4_a3_reg  <= asr32(s3_m3_reg, 5'd13);
            s4_t_reg   <= s3_t_reg;
            s4_err_reg <= s3_err_reg;
            s4_up_reg  <= s3_up_reg;
        end
    end

    // ---------------- S5: B3 and X3 ----------------
    logic [31:0] x3a, b3, x3b;
    logic [31:0] s5_b3_reg, s5_x3_reg;
    logic [11:0] s5_t_reg;
    logic        s5_err_reg;
    logic [23:0] s5_up_reg;

    always_comb
    begin
        x3a = asr32(s4_x1_reg, 5'd11) + s4_a2_reg;
        b3  = asr32((((ac1 << 2) + x3a) << oss_reg) + 32'd2, 5'd2);
        x3b = asr32(s4_a3_reg + asr32(s4_x2_reg, 5'd16) + 32'd2, 5'd2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_b3_reg  <= b3;
            s5_x3_reg  <= x3b + C_B4_BIAS;
            s5_t_reg   <= s4_t_reg;
            s5_err_reg <= s4_err_reg;
            s5_up_reg  <= s4_up_reg;
        end
    end

    // ---------------- S6: B4 and B7 ----------------
    logic [31:0] b4_prod;
    logic [31:0] s6_b4_reg, s6_b7_reg;
    logic [11:0] s6_t_reg;
    logic        s6_err_reg;

    assign b4_prod = ac4 * s5_x3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_b4_reg  <= b4_prod >> 15;
            s6_b7_reg  <= ({8'd0, s5_up_reg} - s5_b3_reg) * (C_B7_BASE >> oss_reg);
            s6_t_reg   <= s5_t_reg;
            s6_err_reg <= s5_err_reg;
        end
    end

    // ---------------- pressure divider ----------------
    // B7 with its top bit set is divided as is and the quotient doubled after.
    logic [31:0] num_p;
    logic [31:0] quo2;
    side2_t      s6_side;
    side2_t      side2_pipe_reg [DIV_W];

    assign num_p       = s6_b7_reg[31] ? s6_b7_reg : (s6_b7_reg << 1);
    assign s6_side.hi  = s6_b7_reg[31];
    assign s6_side.err = s6_err_reg || (s6_b4_reg == '0);
    assign s6_side.t   = s6_t_reg;

    bpc_udiv u_div_p (
        .clk (clk),
        .en  (en),
        .num (num_p),
        .den (s6_b4_reg),
        .quo (quo2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_pipe_reg[0] <= s6_side;
            for (int k = 1; k < DIV_W; k++)
                side2_pipe_reg[k] <= side2_pipe_reg[k-1];
        end
    end

    // ---------------- S8: first correction products ----------------
    side2_t      sd2;
    logic [31:0] p_raw, p8;
    logic [31:0] s8_p_reg, s8_ma_reg, s8_mb_reg;
    side2_t      s8_side_reg;

    always_comb
    begin
        sd2   = side2_pipe_reg[DIV_W-1];
        p_raw = sd2.hi ? (quo2 << 1) : quo2;
        p8    = asr32(p_raw, 5'd8);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_p_reg    <= p_raw;
            s8_ma_reg   <= p8 * p8;
            s8_mb_reg   <= C_P_B * p_raw;
            s8_side_reg <= sd2;
        end
    end

    // ---------------- S9: second correction product ----------------
    logic [31:0] s9_p_reg, s9_mc_reg, s9_x2_reg;
    side2_t      s9_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_p_reg    <= s8_p_reg;
            s9_mc_reg   <= s8_ma_reg * C_P_A;
            s9_x2_reg   <= asr32(s8_mb_reg, 5'd16);
            s9_side_reg <= s8_side_reg;
        end
    end

    // ---------------- S10: final pressure, saturation, output register ----------------
    logic [31:0] p_fin;
    logic [17:0] p_sat;
    logic [11:0] out_t_reg;
    logic [17:0] out_p_reg;
    logic        out_err_reg;

    always_comb
    begin
        p_fin = s9_p_reg + asr32(asr32(s9_mc_reg, 5'd16) + s9_x2_reg + C_P_C, 5'd4);
        if ($signed(p_fin) < 32'sd0)
            p_sat = '0;
        else if ($signed(p_fin) > P_MAX)
            p_sat = P_MAX[17:0];
        else
            p_sat = p_fin[17:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_err_reg <= s9_side_reg.err;
            out_t_reg   <= s9_side_reg.err ? 12'd0 : s9_side_reg.t;
            out_p_reg   <= s9_side_reg.err ? 18'd0 : p_sat;
        end
    end

    assign out_ch.valid              = valid_pipe_reg[PIPE_LAT-1];
    assign out_ch.temperature_tenths = out_t_reg;
    assign out_ch.pressure_pa        = out_p_reg;
    assign out_ch.divide_error       = out_err_reg;

    // ---------------- assertions ----------------
    `BPC_ASSERT_IMPL(a_err_zero, clk, rst_n, out_ch.valid && out_ch.divide_error, out_ch.pressure_pa == '0 && out_ch.temperature_tenths == '0)
    `BPC_ASSERT_NEXT(a_stall_freeze, clk, rst_n, !in_ch.ready, $stable(valid_pipe_reg))
    `BPC_ASSERT_NEXT(a_in_enters, clk, rst_n, in_ch.valid && in_ch.ready, valid_pipe_reg[0])

endmodule
`default_nettype wire
